/* src/can_rx_dispatch_heartbeat_monitor_core_macros.svh */
// Assertion macros shared by the checker of the heartbeat monitor core.
`ifndef CAN_RX_DISPATCH_HEARTBEAT_MONITOR_CORE_MACROS_SVH
`define CAN_RX_DISPATCH_HEARTBEAT_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define CHBM_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define CHBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/chbm_pkg.sv */
// Types, constants and codes shared by the heartbeat monitor core modules.
package chbm_pkg;

	localparam int NODE_COUNT_DEF = 8;

	localparam int NODE_W = 7;
	localparam int PDO_W  = 3;
	localparam int FMAP_W = 8;
	localparam int TMO_W  = 9;
	localparam int PER_W  = 10;
	localparam int CFG_W  = 10;
	localparam int ENT_W  = 1 + TMO_W;

	localparam logic [10:0] PDO1_LO = 11'h181;
	localparam logic [10:0] PDO1_HI = 11'h1FF;
	localparam logic [10:0] PDO2_LO = 11'h281;
	localparam logic [10:0] PDO2_HI = 11'h2FF;
	localparam logic [10:0] PDO3_LO = 11'h381;
	localparam logic [10:0] PDO3_HI = 11'h3FF;
	localparam logic [10:0] PDO4_LO = 11'h481;
	localparam logic [10:0] PDO4_HI = 11'h4FF;
	localparam logic [10:0] HB_LO   = 11'h701;
	localparam logic [10:0] HB_HI   = 11'h77F;
	localparam logic [10:0] NMT_ID  = 11'h000;

	localparam logic [7:0] HB_BOOT   = 8'h00;
	localparam logic [7:0] HB_OPER   = 8'h05;
	localparam logic [7:0] NMT_RESET = 8'h81;

	localparam logic [NODE_W-1:0] OWN_ID_RST = 7'd1;
	localparam logic [TMO_W-1:0]  TMO_RST    = 9'd300;
	localparam logic [PER_W-1:0]  PER_RST    = 10'd100;

	typedef enum logic [1:0] {
		EV_PDO   = 2'd0,
		EV_RESET = 2'd1,
		EV_LOST  = 2'd2,
		EV_SEND  = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		CFG_OWN_ID   = 2'd0,
		CFG_HB_TMO   = 2'd1,
		CFG_PROD_PER = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_RD,
		ST_UPD,
		ST_PROD
	} state_t;

	typedef struct packed {
		logic              hit;
		event_t            ev;
		logic [NODE_W-1:0] node;
		logic [PDO_W-1:0]  pdo;
		logic              hb_hit;
		logic [NODE_W-1:0] hb_node_m1;
	} fdec_t;

	typedef struct packed {
		event_t            ev;
		logic [NODE_W-1:0] node;
		logic [PDO_W-1:0]  pdo;
		logic [FMAP_W-1:0] fmap;
	} res_t;

endpackage

/* src/chbm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module chbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/chbm_frame_dec.sv */
// Decoder that classifies a received frame as PDO, heartbeat or NMT reset.
module chbm_frame_dec import chbm_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic [10:0]       can_id,
	input  logic              is_extended,
	input  logic [3:0]        data_length,
	input  logic [7:0]        first_byte,
	input  logic [7:0]        second_byte,
	input  logic [NODE_W-1:0] own_node_id,
	output fdec_t             dec
);

	logic [NODE_W-1:0] node;
	logic [PDO_W-1:0]  pdo;
	logic              rst_hit;

	always_comb begin
		node = can_id[NODE_W-1:0];
		if (can_id inside {[PDO1_LO:PDO1_HI]}) begin
			pdo = 3'd1;
		end else if (can_id inside {[PDO2_LO:PDO2_HI]}) begin
			pdo = 3'd2;
		end else if (can_id inside {[PDO3_LO:PDO3_HI]}) begin
			pdo = 3'd3;
		end else if (can_id inside {[PDO4_LO:PDO4_HI]}) begin
			pdo = 3'd4;
		end else begin
			pdo = '0;
		end

		rst_hit = (can_id == NMT_ID) && !is_extended && (data_length == 4'd2)
			&& (first_byte == NMT_RESET)
			&& ((second_byte == {1'b0, own_node_id}) || (second_byte == 8'h00));

		dec.hit        = (pdo != '0) || rst_hit;
		dec.ev         = (pdo != '0) ? EV_PDO : EV_RESET;
		dec.node       = (pdo != '0) ? node : second_byte[NODE_W-1:0];
		dec.pdo        = pdo;
		dec.hb_hit     = (can_id inside {[HB_LO:HB_HI]}) && (node != '0)
			&& (int'(node) <= NODE_COUNT) && (data_length == 4'd1)
			&& ((first_byte == HB_BOOT) || (first_byte == HB_OPER));
		dec.hb_node_m1 = node - 7'd1;
	end

endmodule

/* src/can_rx_dispatch_heartbeat_monitor_core.sv */
// CAN receive dispatcher with heartbeat consumer and producer, top level.
// A frame beat passes through ST_IDLE and ST_FLUSH; its result, if any, waits in the pending
// register and moves to the output register once the output is free. A tick beat reads each
// node entry of the timer RAM in ST_RD and writes it back in ST_UPD, then the producer and
// output flush follow. Asynchronous reset clears all nodes (per-entry valid bits), the producer
// counter and the configuration to its defaults; the block is ready at once after reset.
module can_rx_dispatch_heartbeat_monitor_core import chbm_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// can_id[10:0], is_extended[11], data_length[15:12], first_byte[23:16],
	// second_byte[31:24]
	input  logic [31:0]      s_axis_tdata,
	// op[0]
	input  logic [0:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// node_id[6:0], pdo_number[9:7], found_map[17:10], zero fill[23:18]
	output logic [23:0]      m_axis_tdata,
	// event_res[1:0]
	output logic [1:0]       m_axis_tuser,
	output logic             m_axis_tlast,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODE_COUNT - 1);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              send_q, send_d;
	res_t              pend_q, pend_d;
	logic              pend_vld_q, pend_vld_d;
	res_t              out_q, out_d;
	logic              out_vld_q, out_vld_d;
	logic              out_last_q, out_last_d;
	logic [FMAP_W-1:0] fmap_q, fmap_d;
	logic [NODE_COUNT-1:0] vld_q, vld_d;
	logic [PER_W-1:0]  cnt_q, cnt_d;
	logic [NODE_W-1:0] own_q;
	logic [TMO_W-1:0]  tmo_q;
	logic [PER_W-1:0]  per_q;

	fdec_t             dec;
	logic              out_free;
	logic [PER_W-1:0]  cnt_inc;
	logic              prod_send;
	logic [FMAP_W-1:0] hb_mask;
	logic [FMAP_W-1:0] lost_mask;
	logic [ENT_W-1:0]  ent;
	logic [TMO_W:0]    sil_inc;
	logic [TMO_W-1:0]  sil_nx;
	logic              lost;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ENT_W-1:0]  ram_rdata;

	chbm_frame_dec #(
		.NODE_COUNT(NODE_COUNT)
	) u_dec (
		.can_id     (s_axis_tdata[10:0]),
		.is_extended(s_axis_tdata[11]),
		.data_length(s_axis_tdata[15:12]),
		.first_byte (s_axis_tdata[23:16]),
		.second_byte(s_axis_tdata[31:24]),
		.own_node_id(own_q),
		.dec        (dec)
	);

	chbm_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NODE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign out_free  = !out_vld_q || m_axis_tready;
	assign cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 10'd1;
	assign prod_send = (cnt_inc >= per_q);
	assign hb_mask   = FMAP_W'(1) << dec.hb_node_m1;
	assign lost_mask = FMAP_W'(1) << idx_q;

	// An entry that has never been written since reset reads as cleared.
	assign ent     = vld_q[idx_q] ? ram_rdata : '0;
	assign sil_inc = {1'b0, ent[TMO_W-1:0]} + 10'd1;
	assign sil_nx  = (sil_inc < {1'b0, tmo_q}) ? sil_inc[TMO_W-1:0] : tmo_q;
	assign lost    = ent[ENT_W-1] && (sil_nx >= tmo_q);

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		send_d        = send_q;
		pend_d        = pend_q;
		pend_vld_d    = pend_vld_q;
		out_d         = out_q;
		out_vld_d     = out_vld_q && !m_axis_tready;
		out_last_d    = out_last_q;
		fmap_d        = fmap_q;
		vld_d         = vld_q;
		cnt_d         = cnt_q;
		ram_we        = 1'b0;
		ram_waddr     = idx_q;
		ram_wdata     = '0;
		ram_re        = 1'b0;
		s_axis_tready = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (s_axis_tuser[0] == OP_TICK) begin
						idx_d   = '0;
						send_d  = prod_send;
						cnt_d   = prod_send ? '0 : cnt_inc;
						state_d = ST_RD;
					end else begin
						if (dec.hb_hit) begin
							ram_we    = 1'b1;
							ram_waddr = dec.hb_node_m1[IDX_W-1:0];
							ram_wdata = {1'b1, {TMO_W{1'b0}}};
							vld_d[dec.hb_node_m1[IDX_W-1:0]] = 1'b1;
							fmap_d    = fmap_q | hb_mask;
						end
						if (dec.hit) begin
							pend_vld_d = 1'b1;
							pend_d     = '{ev: dec.ev, node: dec.node, pdo: dec.pdo,
								fmap: fmap_q};
						end
						state_d = ST_FLUSH;
					end
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (!(lost && pend_vld_q && !out_free)) begin
					ram_we       = 1'b1;
					ram_wdata    = {ent[ENT_W-1] && !lost, sil_nx};
					vld_d[idx_q] = 1'b1;
					if (lost) begin
						if (pend_vld_q) begin
							out_d      = pend_q;
							out_last_d = 1'b0;
							out_vld_d  = 1'b1;
						end
						fmap_d     = fmap_q & ~lost_mask;
						pend_vld_d = 1'b1;
						pend_d     = '{ev: EV_LOST, node: NODE_W'(idx_q) + 7'd1,
							pdo: '0, fmap: fmap_q & ~lost_mask};
					end
					if (idx_q == IDX_LAST) begin
						state_d = ST_PROD;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_RD;
					end
				end
			end
			ST_PROD: begin
				if (!send_q) begin
					state_d = ST_FLUSH;
				end else if (!pend_vld_q || out_free) begin
					if (pend_vld_q) begin
						out_d      = pend_q;
						out_last_d = 1'b0;
						out_vld_d  = 1'b1;
					end
					pend_vld_d = 1'b1;
					pend_d     = '{ev: EV_SEND, node: '0, pdo: '0, fmap: fmap_q};
					state_d    = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_vld_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_d      = pend_q;
					out_last_d = 1'b1;
					out_vld_d  = 1'b1;
					pend_vld_d = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			send_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			fmap_q     <= '0;
			vld_q      <= '0;
			cnt_q      <= '0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			send_q     <= send_d;
			pend_vld_q <= pend_vld_d;
			out_vld_q  <= out_vld_d;
			fmap_q     <= fmap_d;
			vld_q      <= vld_d;
			cnt_q      <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q     <= pend_d;
		out_q      <= out_d;
		out_last_q <= out_last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= OWN_ID_RST;
			tmo_q <= TMO_RST;
			per_q <= PER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_ID:   own_q <= cfg_wdata[NODE_W-1:0];
				CFG_HB_TMO:   tmo_q <= cfg_wdata[TMO_W-1:0];
				CFG_PROD_PER: per_q <= cfg_wdata[PER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'b0, out_q.fmap, out_q.pdo, out_q.node};
	assign m_axis_tuser  = out_q.ev;
	assign m_axis_tlast  = out_last_q;

endmodule

/* src/chbm_checker.sv */
// Port-level checker for the heartbeat monitor core, with its bind statement.
`include "can_rx_dispatch_heartbeat_monitor_core_macros.svh"

module chbm_checker import chbm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [23:0]      m_axis_tdata,
	input logic [1:0]       m_axis_tuser,
	input logic             m_axis_tlast
);

	// A PDO beat always names PDO 1 to 4.
	`CHBM_ASSERT(a_pdo_number, m_axis_tvalid && (m_axis_tuser == EV_PDO), (m_axis_tdata[9:7] != 3'd0) && (m_axis_tdata[9:7] <= 3'd4), "PDO beat with invalid PDO number")

	// Every other event carries a zero PDO number.
	`CHBM_ASSERT(a_no_pdo_number, m_axis_tvalid && (m_axis_tuser != EV_PDO), m_axis_tdata[9:7] == 3'd0, "non-PDO beat with PDO number")

	// Frame results and the send request always close their input's run.
	`CHBM_ASSERT(a_closing_beat, m_axis_tvalid && ((m_axis_tuser == EV_PDO) || (m_axis_tuser == EV_RESET) || (m_axis_tuser == EV_SEND)), m_axis_tlast, "closing event without tlast")

	// A stalled output beat holds.
	`CHBM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output beat changed")

endmodule

bind can_rx_dispatch_heartbeat_monitor_core chbm_checker u_chbm_checker (.*);

/* tb/sv/tb_can_rx_dispatch_heartbeat_monitor_core.sv */
// Self-checking testbench for the CAN receive dispatcher and heartbeat monitor core.
module tb_can_rx_dispatch_heartbeat_monitor_core;
	import chbm_pkg::*;

	localparam int NODES = NODE_COUNT_DEF;

	typedef struct {
		event_t     ev;
		logic [6:0] node;
		logic [2:0] pdo;
		logic [7:0] fmap;
		logic       last;
	} node_event_t;

	class dispatch_tracker;
		bit          found[NODES];
		int          silence[NODES];
		int          prod_cnt;
		int          own_id;
		int          tmo;
		int          per;
		int          errors;
		int          inputs_seen;
		node_event_t due_events[$];

		function new();
			own_id = 1;
			tmo = 300;
			per = 100;
			prod_cnt = 0;
			errors = 0;
			inputs_seen = 0;
			foreach (found[n]) begin
				found[n] = 1'b0;
				silence[n] = 0;
			end
		endfunction

		function void set_cfg(input cfg_idx_t idx, input int val);
			case (idx)
				CFG_OWN_ID:   own_id = val & 127;
				CFG_HB_TMO:   tmo = val & 511;
				CFG_PROD_PER: per = val & 1023;
				default: ;
			endcase
		endfunction

		function logic [7:0] found_map();
			logic [7:0] m;
			m = '0;
			for (int n = 0; n < NODES && n < 8; n++)
				if (found[n])
					m[n] = 1'b1;
			return m;
		endfunction

		function void add(input event_t ev, input int node, input int pdo);
			node_event_t r;
			r.ev = ev;
			r.node = 7'(node);
			r.pdo = 3'(pdo);
			r.fmap = found_map();
			r.last = 1'b0;
			due_events.push_back(r);
		endfunction

		function void accept_input(input op_t op, input logic [31:0] d);
			int first;
			int id;
			int len;
			int b0;
			int b1;
			int node;
			int pdo;
			int t;
			bit ext;
			node_event_t r;
			first = due_events.size();
			inputs_seen++;
			if (op == OP_FRAME) begin
				id = int'(d[10:0]);
				ext = d[11];
				len = int'(d[15:12]);
				b0 = int'(d[23:16]);
				b1 = int'(d[31:24]);
				node = id & 127;
				pdo = 0;
				if (id >= PDO1_LO && id <= PDO1_HI) pdo = 1;
				else if (id >= PDO2_LO && id <= PDO2_HI) pdo = 2;
				else if (id >= PDO3_LO && id <= PDO3_HI) pdo = 3;
				else if (id >= PDO4_LO && id <= PDO4_HI) pdo = 4;
				if (pdo != 0)
					add(EV_PDO, node, pdo);
				if (id >= HB_LO && id <= HB_HI && node >= 1 && node <= NODES && len == 1
						&& (b0 == HB_BOOT || b0 == HB_OPER)) begin
					found[node-1] = 1'b1;
					silence[node-1] = 0;
				end
				if (id == NMT_ID && !ext && len == 2 && b0 == NMT_RESET
						&& (b1 == own_id || b1 == 0))
					add(EV_RESET, b1, 0);
			end else begin
				for (int n = 0; n < NODES; n++) begin
					t = silence[n] + 1;
					silence[n] = (t < tmo) ? t : tmo;
				end
				for (int n = 0; n < NODES; n++) begin
					if (found[n] && silence[n] >= tmo) begin
						found[n] = 1'b0;
						add(EV_LOST, n + 1, 0);
					end
				end
				if (prod_cnt < 1023)
					prod_cnt++;
				if (prod_cnt >= per) begin
					prod_cnt = 0;
					add(EV_SEND, 0, 0);
				end
			end
			if (due_events.size() > first) begin
				r = due_events.pop_back();
				r.last = 1'b1;
				due_events.push_back(r);
			end
		endfunction

		function void match_event(input logic [1:0] ev, input logic [23:0] d, input logic lst);
			node_event_t e;
			if (due_events.size() == 0) begin
				$error("unexpected beat: event_res %0d node_id %0d", ev, d[6:0]);
				errors++;
				return;
			end
			e = due_events.pop_front();
			if (ev !== e.ev) begin
				$error("event_res expected %0d actual %0d", e.ev, ev);
				errors++;
			end
			if (d[6:0] !== e.node) begin
				$error("node_id expected %0d actual %0d", e.node, d[6:0]);
				errors++;
			end
			if (d[9:7] !== e.pdo) begin
				$error("pdo_number expected %0d actual %0d", e.pdo, d[9:7]);
				errors++;
			end
			if (d[17:10] !== e.fmap) begin
				$error("found_map expected %0h actual %0h", e.fmap, d[17:10]);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last expected %0d actual %0d", e.last, lst);
				errors++;
			end
		endfunction

		function int pending();
			return due_events.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// can_id[10:0], is_extended[11], data_length[15:12], first_byte[23:16],
	// second_byte[31:24]
	logic [31:0]      s_axis_tdata = '0;
	// op[0]
	logic [0:0]       s_axis_tuser = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// node_id[6:0], pdo_number[9:7], found_map[17:10], zero fill[23:18]
	logic [23:0]      m_axis_tdata;
	// event_res[1:0]
	logic [1:0]       m_axis_tuser;
	logic             m_axis_tlast;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	dispatch_tracker tracker = new();
	bit              tx_fast = 1'b0;

	can_rx_dispatch_heartbeat_monitor_core #(
		.NODE_COUNT(NODES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] frame(input logic [10:0] id, input logic ext,
			input logic [3:0] len, input logic [7:0] b0, input logic [7:0] b1);
		return {b1, b0, len, ext, id};
	endfunction

	task automatic offer_item(input op_t op, input logic [31:0] data);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		tracker.accept_input(op, data);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (2 * NODES + 24) @(posedge clk);
	endtask

	task automatic write_settings(input int own, input int tmo, input int per);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OWN_ID;
		cfg_wdata <= CFG_W'(own);
		@(posedge clk);
		tracker.set_cfg(CFG_OWN_ID, own);
		cfg_index <= CFG_HB_TMO;
		cfg_wdata <= CFG_W'(tmo);
		@(posedge clk);
		tracker.set_cfg(CFG_HB_TMO, tmo);
		cfg_index <= CFG_PROD_PER;
		cfg_wdata <= CFG_W'(per);
		@(posedge clk);
		tracker.set_cfg(CFG_PROD_PER, per);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int k;
		int node;
		int sel;
		logic [7:0] tgt;
		k = $urandom_range(0, 99);
		if (k < 40) begin
			offer_item(OP_TICK, $urandom());
		end else if (k < 62) begin
			node = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, NODES);
			if ($urandom_range(0, 4) != 0)
				offer_item(OP_FRAME, frame(11'(11'h700 | node), 1'($urandom_range(0, 1)), 4'd1,
					$urandom_range(0, 1) ? HB_OPER : HB_BOOT, 8'($urandom())));
			else
				offer_item(OP_FRAME, frame(11'(11'h700 | node), 1'($urandom_range(0, 1)),
					4'($urandom_range(0, 15)), 8'($urandom_range(0, 7)), 8'($urandom())));
		end else if (k < 74) begin
			offer_item(OP_FRAME, frame(11'($urandom_range(1, 4) * 256 + 128 + $urandom_range(0, 127)),
				1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 8'($urandom()),
				8'($urandom())));
		end else if (k < 86) begin
			sel = $urandom_range(0, 2);
			tgt = (sel == 0) ? 8'(tracker.own_id) : (sel == 1) ? 8'd0 : 8'($urandom());
			if ($urandom_range(0, 4) != 0)
				offer_item(OP_FRAME, frame(NMT_ID, 1'b0, 4'd2, NMT_RESET, tgt));
			else
				offer_item(OP_FRAME, frame(11'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					4'($urandom_range(0, 15)), $urandom_range(0, 1) ? NMT_RESET : 8'($urandom()), tgt));
		end else begin
			offer_item(OP_FRAME, $urandom());
		end
	endtask

	initial begin : result_side
		int gap;
		bit fast;
		bit held;
		fast = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && tracker.inputs_seen >= 70) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if ($urandom_range(0, 19) == 0)
				fast = !fast;
			gap = fast ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			tracker.match_event(m_axis_tuser, m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin : stimulus
		int own;
		int tmo;
		int per;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_item(OP_FRAME, frame(PDO1_LO, 1'b0, 4'd1, 8'h00, 8'h00));
		offer_item(OP_FRAME, frame(PDO1_HI, 1'b0, 4'd8, 8'hFF, 8'hFF));
		offer_item(OP_FRAME, frame(PDO2_LO, 1'b1, 4'd0, 8'h12, 8'h34));
		offer_item(OP_FRAME, frame(PDO2_HI, 1'b0, 4'd2, 8'h81, 8'h00));
		offer_item(OP_FRAME, frame(PDO3_LO, 1'b0, 4'd3, 8'h00, 8'h01));
		offer_item(OP_FRAME, frame(PDO3_HI, 1'b1, 4'd4, 8'h05, 8'h05));
		offer_item(OP_FRAME, frame(PDO4_LO, 1'b0, 4'd5, 8'hAA, 8'h55));
		offer_item(OP_FRAME, frame(PDO4_HI, 1'b0, 4'd6, 8'h55, 8'hAA));
		offer_item(OP_FRAME, frame(11'h180, 1'b0, 4'd1, 8'h00, 8'h00));
		offer_item(OP_FRAME, frame(11'h500, 1'b0, 4'd1, 8'h00, 8'h00));
		offer_item(OP_FRAME, frame(11'h701, 1'b0, 4'd1, HB_BOOT, 8'h00));
		offer_item(OP_FRAME, frame(11'h708, 1'b1, 4'd1, HB_OPER, 8'hFF));
		offer_item(OP_FRAME, frame(11'h709, 1'b0, 4'd1, HB_OPER, 8'h00));
		offer_item(OP_FRAME, frame(11'h703, 1'b0, 4'd1, 8'h04, 8'h00));
		offer_item(OP_FRAME, frame(11'h703, 1'b0, 4'd2, HB_OPER, 8'h00));
		offer_item(OP_FRAME, frame(HB_HI, 1'b0, 4'd1, HB_OPER, 8'h00));
		offer_item(OP_FRAME, frame(NMT_ID, 1'b0, 4'd2, NMT_RESET, 8'd1));
		offer_item(OP_FRAME, frame(NMT_ID, 1'b0, 4'd2, NMT_RESET, 8'd0));
		offer_item(OP_FRAME, frame(NMT_ID, 1'b0, 4'd2, NMT_RESET, 8'd5));
		offer_item(OP_FRAME, frame(NMT_ID, 1'b1, 4'd2, NMT_RESET, 8'd1));
		offer_item(OP_FRAME, frame(NMT_ID, 1'b0, 4'd10, NMT_RESET, 8'd0));
		offer_item(OP_FRAME, frame(NMT_ID, 1'b0, 4'd2, 8'h82, 8'd0));
		offer_item(OP_TICK, 32'h0);
		offer_item(OP_TICK, 32'hFFFF_FFFF);
		offer_item(OP_FRAME, frame(11'h7FF, 1'b1, 4'd15, 8'hFF, 8'hFF));

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: begin own = 127; tmo = 1;   per = 1;    end
				1: begin own = 42;  tmo = 6;   per = 9;    end
				2: begin own = 1;   tmo = 511; per = 1023; end
				3: begin own = 99;  tmo = 0;   per = 0;    end
				default: begin
					own = $urandom_range(1, 127);
					tmo = $urandom_range(2, 12);
					per = $urandom_range(2, 15);
				end
			endcase
			write_settings(own, tmo, per);
			tx_fast = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < 33; i++) begin
				if (ph == 4 && i == 16)
					settle();
				random_item();
			end
		end
		settle();

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/chbm_pkg.sv
src/chbm_ram.sv
src/chbm_frame_dec.sv
src/can_rx_dispatch_heartbeat_monitor_core.sv
src/chbm_checker.sv
tb/sv/tb_can_rx_dispatch_heartbeat_monitor_core.sv
